FILE: hw/rtl/cse_pkg.sv
// ============================================================================
// cse_pkg
// Shared types and constants of the cubic spline evaluator.
// ============================================================================
package cse_pkg;

  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_FRAC_BITS    = 16;

  // registered steps through one fixed-point multiplier
  localparam int MUL_LAT = 4;

  localparam logic [63:0] TERM_LIMIT = 64'h1000_0000_0000_0000;

  localparam logic       CMD_LOAD = 1'b0;
  localparam logic       CMD_EVAL = 1'b1;

  localparam logic [1:0] CFG_SEGMENT_COUNT = 2'd0;
  localparam logic [1:0] CFG_START_SLOPE   = 2'd1;
  localparam logic [1:0] CFG_END_SLOPE     = 2'd2;

  localparam logic [6:0] SEG_COUNT_RESET = 7'd1;

  typedef enum logic [1:0] {
    RANGE_INSIDE = 2'd0,
    RANGE_BELOW  = 2'd1,
    RANGE_ABOVE  = 2'd2
  } range_e;

  typedef struct packed {
    logic               command;
    logic [6:0]         entry_index;
    logic signed [31:0] knot_x;
    logic signed [31:0] knot_y;
    logic signed [31:0] slope_coef;
    logic signed [31:0] quad_coef;
    logic signed [31:0] cubic_coef;
    logic signed [31:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] first_derivative;
    logic signed [31:0] second_derivative;
    logic [5:0]         segment;
    logic [1:0]         range_status;
    logic               saturated;
  } result_t;

endpackage

FILE: hw/rtl/cse_mulq.sv
// ============================================================================
// cse_mulq
// Pipelined fixed-point multiply: floor(a*b / 2^FRAC_BITS), clamped to 2^60.
// ============================================================================
module cse_mulq #(
  parameter int FRAC_BITS = cse_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p,
  output logic               clip
);
  import cse_pkg::*;

  localparam logic [127:0] REM_MASK = (128'd1 << FRAC_BITS) - 128'd1;

  logic         neg1, neg2, neg3;
  logic [63:0]  ma1, mb1;
  logic [63:0]  pp00, pp01, pp10, pp11;
  logic [127:0] prod;
  logic [127:0] quo, quo_adj;
  logic         rem_nz, over;
  logic [63:0]  mag;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[63] ^ b[63];
      ma1  <= a[63] ? 64'(-a) : 64'(a);
      mb1  <= b[63] ? 64'(-b) : 64'(b);
      neg2 <= neg1;
      pp00 <= 64'(ma1[31:0])  * 64'(mb1[31:0]);
      pp01 <= 64'(ma1[31:0])  * 64'(mb1[63:32]);
      pp10 <= 64'(ma1[63:32]) * 64'(mb1[31:0]);
      pp11 <= 64'(ma1[63:32]) * 64'(mb1[63:32]);
      neg3 <= neg2;
      prod <= {64'b0, pp00} + {32'b0, pp01, 32'b0} + {32'b0, pp10, 32'b0} + {pp11, 64'b0};
      p    <= neg3 ? -$signed(mag) : $signed(mag);
      clip <= over;
    end
  end

  always_comb begin
    quo     = prod >> FRAC_BITS;
    rem_nz  = |(prod & REM_MASK);
    quo_adj = quo + {127'b0, neg3 & rem_nz};
    over    = quo_adj > {64'b0, TERM_LIMIT};
    mag     = over ? TERM_LIMIT : quo_adj[63:0];
  end

endmodule

FILE: hw/rtl/cubic_spline_evaluator_unit.sv
// ============================================================================
// cubic_spline_evaluator_unit
// Piecewise cubic spline table with segment search and evaluation.
// ============================================================================
// Takes one item per clock and returns one result per item, in order. A load
// writes one table entry; an evaluate finds its segment by bisection and
// returns value, first and second derivative in saturated Q16.16. The pipeline
// holds an input register, one stage per bisection step, each reading its own
// copy of the knot table, then a table read, a difference stage and three
// chained multiplier levels of four stages each, a summing stage and the
// output register. Every table is replicated per read stage and written as
// the load passes that stage, so loads and evaluations keep their order. The
// table holds no defined contents until loaded. A stalled output holds the
// whole pipeline.
module cubic_spline_evaluator_unit #(
  parameter int MAX_SEGMENTS = cse_pkg::DEF_MAX_SEGMENTS,
  parameter int FRAC_BITS    = cse_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  cse_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output cse_pkg::result_t   result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import cse_pkg::*;

  localparam int SW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int AW    = $clog2(MAX_SEGMENTS + 1);
  localparam int DEPTH = MAX_SEGMENTS + 1;
  localparam int NS    = SW;
  localparam logic [31:0] MAX_U = 32'(MAX_SEGMENTS);

  typedef struct packed {
    logic               valid;
    logic               eval;
    range_e             status;
    logic [SW-1:0]      seg;
    logic signed [31:0] y;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [63:0] dx;
    logic signed [63:0] dsq;
    logic signed [63:0] adx;
    logic signed [63:0] bdx;
    logic signed [63:0] cdx;
    logic signed [63:0] bsq;
    logic signed [63:0] csq;
    logic               clip;
  } ctx_t;

  function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    if (v < 64'shFFFF_FFFF_8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic load_ok(input in_item_t it, input logic [31:0] lim);
    return (it.command == CMD_LOAD) && ({25'b0, it.entry_index} <= lim);
  endfunction

  // configuration
  logic [6:0]         segment_count;
  logic signed [31:0] start_slope;
  logic signed [31:0] end_slope;
  logic [31:0]        n32;
  logic [AW-1:0]      n;
  logic [SW-1:0]      n_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= SEG_COUNT_RESET;
      start_slope   <= '0;
      end_slope     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SEGMENT_COUNT: segment_count <= cfg_data[6:0];
        CFG_START_SLOPE:   start_slope   <= cfg_data;
        CFG_END_SLOPE:     end_slope     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    n32 = {25'b0, segment_count};
    if (n32 == 32'd0) n32 = 32'd1;
    else if (n32 > MAX_U) n32 = MAX_U;
    n      = AW'(n32);
    n_last = SW'(n32 - 32'd1);
  end

  // pipeline control
  logic adv;
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  // search stages
  logic          st_valid [0:NS+1];
  in_item_t      st_item  [0:NS+1];
  logic [SW-1:0] st_idx   [1:NS];
  range_e        st_status[2:NS+1];
  logic [SW-1:0] idx_eff  [0:NS];
  range_e        stat     [1:NS];
  logic [SW-1:0] scand    [0:NS-1];
  logic signed [31:0] srd [0:NS-1];

  logic signed [31:0] e0_mem [DEPTH];
  logic signed [31:0] en_mem [DEPTH];
  logic signed [31:0] e0_rd, en_rd;
  range_e             status_p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NS + 1; k++) st_valid[k] <= 1'b0;
    end else if (adv) begin
      st_valid[0] <= item_valid;
      for (int k = 1; k <= NS + 1; k++) st_valid[k] <= st_valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_item[0] <= item;
      for (int k = 1; k <= NS + 1; k++) st_item[k] <= st_item[k-1];
      for (int k = 1; k <= NS; k++) st_idx[k] <= idx_eff[k-1];
      for (int k = 2; k <= NS + 1; k++) st_status[k] <= stat[k-1];
      if (st_valid[0] && load_ok(st_item[0], MAX_U)) begin
        e0_mem[AW'(st_item[0].entry_index)] <= st_item[0].knot_x;
        en_mem[AW'(st_item[0].entry_index)] <= st_item[0].knot_x;
      end
      e0_rd <= e0_mem[AW'(0)];
      en_rd <= en_mem[n];
    end
  end

  always_comb begin
    if (st_item[1].query_x > en_rd) status_p1 = RANGE_ABOVE;
    else if (st_item[1].query_x < e0_rd) status_p1 = RANGE_BELOW;
    else status_p1 = RANGE_INSIDE;
    stat[1] = status_p1;
    for (int k = 2; k <= NS; k++) stat[k] = st_status[k];
    idx_eff[0] = '0;
    for (int k = 1; k <= NS; k++) begin
      if ((AW'(scand[k-1]) < n) && (srd[k-1] <= st_item[k].query_x))
        idx_eff[k] = scand[k-1];
      else
        idx_eff[k] = st_idx[k];
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_search
    logic signed [31:0] mem [DEPTH];
    logic [SW-1:0]      cand;
    assign cand = idx_eff[j] | (SW'(1) << (SW - 1 - j));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (st_valid[j] && load_ok(st_item[j], MAX_U))
          mem[AW'(st_item[j].entry_index)] <= st_item[j].knot_x;
        srd[j]   <= mem[AW'(cand)];
        scand[j] <= cand;
      end
    end
  end

  // segment table read
  logic signed [31:0] fx_mem [DEPTH];
  logic signed [31:0] fy_mem [DEPTH];
  logic signed [31:0] fa_mem [MAX_SEGMENTS];
  logic signed [31:0] fb_mem [MAX_SEGMENTS];
  logic signed [31:0] fc_mem [MAX_SEGMENTS];
  logic [SW-1:0]      seg_final;
  logic [AW-1:0]      faddr;
  logic [SW-1:0]      r_seg;
  logic signed [31:0] rd_x, rd_y, rd_a, rd_b, rd_c;

  always_comb begin
    case (stat[NS])
      RANGE_ABOVE: begin
        seg_final = n_last;
        faddr     = n;
      end
      RANGE_BELOW: begin
        seg_final = '0;
        faddr     = '0;
      end
      default: begin
        seg_final = idx_eff[NS];
        faddr     = AW'(idx_eff[NS]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (st_valid[NS] && load_ok(st_item[NS], MAX_U)) begin
        fx_mem[AW'(st_item[NS].entry_index)] <= st_item[NS].knot_x;
        fy_mem[AW'(st_item[NS].entry_index)] <= st_item[NS].knot_y;
      end
      if (st_valid[NS] && load_ok(st_item[NS], MAX_U - 32'd1)) begin
        fa_mem[SW'(st_item[NS].entry_index)] <= st_item[NS].slope_coef;
        fb_mem[SW'(st_item[NS].entry_index)] <= st_item[NS].quad_coef;
        fc_mem[SW'(st_item[NS].entry_index)] <= st_item[NS].cubic_coef;
      end
      rd_x  <= fx_mem[faddr];
      rd_y  <= fy_mem[faddr];
      rd_a  <= fa_mem[seg_final];
      rd_b  <= fb_mem[seg_final];
      rd_c  <= fc_mem[seg_final];
      r_seg <= seg_final;
    end
  end

  // difference stage
  ctx_t d_ctx, d_next;
  logic r_inside;

  always_comb begin
    r_inside      = st_status[NS+1] == RANGE_INSIDE;
    d_next        = '0;
    d_next.valid  = st_valid[NS+1];
    d_next.eval   = st_item[NS+1].command == CMD_EVAL;
    d_next.status = st_status[NS+1];
    d_next.seg    = r_seg;
    d_next.y      = rd_y;
    d_next.b      = rd_b;
    d_next.c      = rd_c;
    d_next.dx     = sx64(st_item[NS+1].query_x) - sx64(rd_x);
    if (r_inside) d_next.a = rd_a;
    else if (st_status[NS+1] == RANGE_ABOVE) d_next.a = end_slope;
    else d_next.a = start_slope;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctx.valid <= 1'b0;
    end else if (adv) begin
      d_ctx <= d_next;
    end
  end

  // multiplier levels
  ctx_t dl1 [MUL_LAT];
  ctx_t dl2 [MUL_LAT];
  ctx_t dl3 [MUL_LAT];
  ctx_t c1, c2, c3;
  logic signed [63:0] m_dsq, m_adx, m_bdx, m_cdx, m_dcu, m_bsq, m_csq, m_ccu;
  logic k_dsq, k_adx, k_bdx, k_cdx, k_dcu, k_bsq, k_csq, k_ccu;

  cse_mulq #(.FRAC_BITS(FRAC_BITS)) u_dsq (.clk, .en(adv), .a(d_ctx.dx), .b(d_ctx.dx),
    .p(m_dsq), .clip(k_dsq));
  cse_mulq #(.FRAC_BITS(FRAC_BITS)) u_adx (.clk, .en(adv), .a(sx64(d_ctx.a)), .b(d_ctx.dx),
    .p(m_adx), .clip(k_adx));
  cse_mulq #(.FRAC_BITS(FRAC_BITS)) u_bdx (.clk, .en(adv), .a(sx64(d_ctx.b)), .b(d_ctx.dx),
    .p(m_bdx), .clip(k_bdx));
  cse_mulq #(.FRAC_BITS(FRAC_BITS)) u_cdx (.clk, .en(adv), .a(sx64(d_ctx.c)), .b(d_ctx.dx),
    .p(m_cdx), .clip(k_cdx));
  cse_mulq #(.FRAC_BITS(FRAC_BITS)) u_dcu (.clk, .en(adv), .a(m_dsq), .b(dl1[MUL_LAT-1].dx),
    .p(m_dcu), .clip(k_dcu));
  cse_mulq #(.FRAC_BITS(FRAC_BITS)) u_bsq (.clk, .en(adv), .a(sx64(dl1[MUL_LAT-1].b)),
    .b(m_dsq), .p(m_bsq), .clip(k_bsq));
  cse_mulq #(.FRAC_BITS(FRAC_BITS)) u_csq (.clk, .en(adv), .a(sx64(dl1[MUL_LAT-1].c)),
    .b(m_dsq), .p(m_csq), .clip(k_csq));
  cse_mulq #(.FRAC_BITS(FRAC_BITS)) u_ccu (.clk, .en(adv), .a(sx64(dl2[MUL_LAT-1].c)),
    .b(m_dcu), .p(m_ccu), .clip(k_ccu));

  always_comb begin
    c1      = dl1[MUL_LAT-1];
    c1.dsq  = m_dsq;
    c1.adx  = m_adx;
    c1.bdx  = m_bdx;
    c1.cdx  = m_cdx;
    c1.clip = k_adx | ((c1.status == RANGE_INSIDE) & (k_dsq | k_bdx | k_cdx));
    c2      = dl2[MUL_LAT-1];
    c2.bsq  = m_bsq;
    c2.csq  = m_csq;
    c2.clip = c2.clip | ((c2.status == RANGE_INSIDE) & (k_dcu | k_bsq | k_csq));
    c3      = dl3[MUL_LAT-1];
    c3.clip = c3.clip | ((c3.status == RANGE_INSIDE) & k_ccu);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MUL_LAT; i++) begin
        dl1[i].valid <= 1'b0;
        dl2[i].valid <= 1'b0;
        dl3[i].valid <= 1'b0;
      end
    end else if (adv) begin
      dl1[0] <= d_ctx;
      dl2[0] <= c1;
      dl3[0] <= c2;
      for (int i = 1; i < MUL_LAT; i++) begin
        dl1[i] <= dl1[i-1];
        dl2[i] <= dl2[i-1];
        dl3[i] <= dl3[i-1];
      end
    end
  end

  // summing stage
  logic               s_valid, s_eval, s_clip;
  range_e             s_status;
  logic [SW-1:0]      s_seg;
  logic signed [63:0] s_v, s_d1, s_d2;
  logic signed [63:0] v_next, d1_next, d2_next;

  always_comb begin
    if (c3.status == RANGE_INSIDE) begin
      v_next  = sx64(c3.y) + c3.adx + c3.bsq + m_ccu;
      d1_next = sx64(c3.a) + (c3.bdx <<< 1) + c3.csq + (c3.csq <<< 1);
      d2_next = (sx64(c3.b) <<< 1) + (c3.cdx <<< 2) + (c3.cdx <<< 1);
    end else begin
      v_next  = sx64(c3.y) + c3.adx;
      d1_next = sx64(c3.a);
      d2_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (adv) begin
      s_valid <= c3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_eval   <= c3.eval;
      s_status <= c3.status;
      s_seg    <= c3.seg;
      s_clip   <= c3.clip;
      s_v      <= v_next;
      s_d1     <= d1_next;
      s_d2     <= d2_next;
    end
  end

  // output register
  logic [32:0] sat_v, sat_d1, sat_d2;
  result_t     result_next;

  always_comb begin
    sat_v       = sat32(s_v);
    sat_d1      = sat32(s_d1);
    sat_d2      = sat32(s_d2);
    result_next = '0;
    if (s_eval) begin
      result_next.value             = sat_v[31:0];
      result_next.first_derivative  = sat_d1[31:0];
      result_next.second_derivative = sat_d2[31:0];
      result_next.segment           = 6'(s_seg);
      result_next.range_status      = s_status;
      result_next.saturated         = s_clip | sat_v[32] | sat_d1[32] | sat_d2[32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) result <= result_next;
  end

  a_extrap_flat: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.range_status != RANGE_INSIDE) |-> result.second_derivative == 32'sd0)
    else $error("nonzero second derivative outside the knots");

  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    s_valid && !s_eval && adv |=> result == '0)
    else $error("load transfer produced a nonzero result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s_valid) && $stable(d_ctx.valid) && $stable(st_valid[0]))
    else $error("pipeline advanced while the output was stalled");

endmodule

FILE: tb/tb.sv
// ============================================================================
// Cubic spline evaluator testbench
// Loads spline tables, evaluates queries inside and outside the knots and
// checks every result, field by field, against an exact Q16.16 predictor kept
// in step with every load and register write, under several idle patterns.
// ============================================================================
`timescale 1ns / 100ps

module tb;
  import cse_pkg::*;

  localparam int NKNOT = DEF_MAX_SEGMENTS;
  localparam int FB    = DEF_FRAC_BITS;
  localparam logic signed [127:0] TERM_MAX = 128'sd1 <<< 60;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  cubic_spline_evaluator_unit uut (.*);

  always #5 clk = ~clk;

  logic signed [31:0] kx_tab [0:NKNOT];
  logic signed [31:0] ky_tab [0:NKNOT];
  logic signed [31:0] a_tab [0:NKNOT-1];
  logic signed [31:0] b_tab [0:NKNOT-1];
  logic signed [31:0] c_tab [0:NKNOT-1];
  logic [6:0] seg_cnt = SEG_COUNT_RESET;
  logic signed [31:0] lo_slope = '0;
  logic signed [31:0] hi_slope = '0;
  logic signed [31:0] gen_x [0:NKNOT];

  in_item_t pending_items[$];
  result_t  spline_results[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_sender = 1'b0;
  bit failed = 1'b0;

  function automatic logic signed [127:0] mul_q(input logic signed [127:0] x,
                                                 input logic signed [127:0] y,
                                                 inout bit clip);
    logic signed [127:0] r;
    r = (x * y) >>> FB;
    if (r > TERM_MAX) begin
      clip = 1'b1;
      r = TERM_MAX;
    end else if (r < -TERM_MAX) begin
      clip = 1'b1;
      r = -TERM_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [127:0] v,
                                               inout bit clip);
    if (v > 128'sh7fff_ffff) begin
      clip = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -128'sh8000_0000) begin
      clip = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic result_t spline_eval(input in_item_t it);
    result_t r;
    bit clip;
    int n, s;
    logic signed [127:0] q, v, d1, d2, dx, dsq, dcu, a, b, c;
    r = '0;
    clip = 1'b0;
    if (it.command == CMD_LOAD) begin
      if (it.entry_index <= NKNOT) begin
        kx_tab[it.entry_index] = it.knot_x;
        ky_tab[it.entry_index] = it.knot_y;
        if (it.entry_index < NKNOT) begin
          a_tab[it.entry_index] = it.slope_coef;
          b_tab[it.entry_index] = it.quad_coef;
          c_tab[it.entry_index] = it.cubic_coef;
        end
      end
      return r;
    end
    n = seg_cnt;
    if (n < 1) n = 1;
    if (n > NKNOT) n = NKNOT;
    q = it.query_x;
    if (q > kx_tab[n]) begin
      r.range_status = RANGE_ABOVE;
      s = n - 1;
      v = ky_tab[n] + mul_q(q - kx_tab[n], hi_slope, clip);
      d1 = hi_slope;
      d2 = 0;
    end else if (q < kx_tab[0]) begin
      r.range_status = RANGE_BELOW;
      s = 0;
      v = ky_tab[0] + mul_q(q - kx_tab[0], lo_slope, clip);
      d1 = lo_slope;
      d2 = 0;
    end else begin
      r.range_status = RANGE_INSIDE;
      s = 0;
      for (int i = n; i > 0; i--) begin
        if (kx_tab[i-1] <= q) begin
          s = i - 1;
          break;
        end
      end
      a = a_tab[s];
      b = b_tab[s];
      c = c_tab[s];
      dx = q - kx_tab[s];
      dsq = mul_q(dx, dx, clip);
      dcu = mul_q(dsq, dx, clip);
      v = ky_tab[s] + mul_q(a, dx, clip) + mul_q(b, dsq, clip) + mul_q(c, dcu, clip);
      d1 = a + 2 * mul_q(b, dx, clip) + 3 * mul_q(c, dsq, clip);
      d2 = 2 * b + 6 * mul_q(c, dx, clip);
    end
    r.value = sat_32(v, clip);
    r.first_derivative = sat_32(d1, clip);
    r.second_derivative = sat_32(d2, clip);
    r.segment = s[5:0];
    r.saturated = clip;
    return r;
  endfunction

  always @(posedge clk) begin
    in_item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (!hold_sender && pending_items.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        spline_results.insert(spline_results.size(), spline_eval(nxt));
        item <= nxt;
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (spline_results.size() == 0) begin
        $error("unexpected result transfer");
        failed = 1'b1;
      end else begin
        exp_r = spline_results.pop_front();
        if (result.value !== exp_r.value) begin
          $error("value: expected %0d, got %0d", exp_r.value, result.value);
          failed = 1'b1;
        end
        if (result.first_derivative !== exp_r.first_derivative) begin
          $error("first_derivative: expected %0d, got %0d",
                 exp_r.first_derivative, result.first_derivative);
          failed = 1'b1;
        end
        if (result.second_derivative !== exp_r.second_derivative) begin
          $error("second_derivative: expected %0d, got %0d",
                 exp_r.second_derivative, result.second_derivative);
          failed = 1'b1;
        end
        if (result.segment !== exp_r.segment) begin
          $error("segment: expected %0d, got %0d", exp_r.segment, result.segment);
          failed = 1'b1;
        end
        if (result.range_status !== exp_r.range_status) begin
          $error("range_status: expected %0d, got %0d",
                 exp_r.range_status, result.range_status);
          failed = 1'b1;
        end
        if (result.saturated !== exp_r.saturated) begin
          $error("saturated: expected %0d, got %0d", exp_r.saturated, result.saturated);
          failed = 1'b1;
        end
      end
    end
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(131071)) - 65536;
      2: return $signed($urandom_range(2097151)) - 1048576;
      default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  task automatic push_load(input int idx, input logic [31:0] x);
    in_item_t it;
    it = rand_item();
    it.command = CMD_LOAD;
    it.entry_index = 7'(idx);
    it.knot_x = x;
    it.knot_y = rand_coef();
    it.slope_coef = rand_coef();
    it.quad_coef = rand_coef();
    it.cubic_coef = rand_coef();
    if (idx <= NKNOT) gen_x[idx] = x;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_eval(input logic [31:0] q);
    in_item_t it;
    it = rand_item();
    it.command = CMD_EVAL;
    it.query_x = q;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_table();
    logic signed [63:0] x;
    int step_max;
    x = -64'sd2147483648 + $urandom_range(1 << 20);
    step_max = 1 << $urandom_range(25, 6);
    for (int i = 0; i <= NKNOT; i++) begin
      push_load(i, x[31:0]);
      x = x + $urandom_range(step_max, 1);
    end
  endtask

  task automatic push_query();
    int k;
    k = $urandom_range(NKNOT);
    case ($urandom_range(3))
      0: push_eval($urandom);
      1: push_eval(gen_x[k]);
      default: push_eval(gen_x[k] + $urandom_range(1 << $urandom_range(24, 2)));
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || spline_results.size() > 0 || item_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SEGMENT_COUNT: seg_cnt = data[6:0];
      CFG_START_SLOPE:   lo_slope = data;
      CFG_END_SLOPE:     hi_slope = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;  stall_pct = 0;
          write_reg(CFG_SEGMENT_COUNT, NKNOT);
          write_reg(CFG_START_SLOPE, 32'h0001_8000);
          write_reg(CFG_END_SLOPE, 32'hfffe_4000);
        end
        1: begin
          send_idle_pct = 64; stall_pct = 0;
          write_reg(CFG_SEGMENT_COUNT, 1);
          write_reg(CFG_START_SLOPE, 32'h8000_0000);
          write_reg(CFG_END_SLOPE, 32'h7fff_ffff);
        end
        2: begin
          send_idle_pct = 0;  stall_pct = 64;
          write_reg(CFG_SEGMENT_COUNT, 0);
          write_reg(CFG_UNUSED, $urandom);
          write_reg(CFG_SEGMENT_COUNT, 127);
          write_reg(CFG_START_SLOPE, 32'h7fff_ffff);
          write_reg(CFG_END_SLOPE, 32'h8000_0000);
        end
        default: begin
          send_idle_pct = 25; stall_pct = 25;
          write_reg(CFG_SEGMENT_COUNT, $urandom_range(NKNOT, 1));
          write_reg(CFG_START_SLOPE, rand_coef());
          write_reg(CFG_END_SLOPE, rand_coef());
        end
      endcase
      push_table();
      if (p == 0) begin
        push_eval(32'h8000_0000);
        push_eval(32'h7fff_ffff);
        push_eval(gen_x[0]);
        push_eval(gen_x[NKNOT]);
        push_eval(gen_x[5]);
        push_eval(gen_x[5] - 1);
        push_load(NKNOT, gen_x[NKNOT - 1] + 1);
        push_eval(32'h7fff_0000);
        push_load(127, $urandom);
        push_load(NKNOT + 1, $urandom);
        push_eval(gen_x[3]);
        push_load(NKNOT, gen_x[0] - 2);
        push_eval(gen_x[0] - 1);
        push_eval(gen_x[0]);
        push_load(NKNOT, 32'h7fff_ffff);
      end
      for (int i = 0; i < 85; i++) begin
        if ($urandom_range(9) == 0)
          push_load($urandom_range(127, NKNOT + 1), $urandom);
        else if ($urandom_range(299) == 0)
          push_table();
        else
          push_query();
      end
      if (p == 1) begin
        while (pending_items.size() > 60) @(posedge clk);
        hold_sender = 1'b1;
        while (spline_results.size() > 0 || item_valid) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_idle();
    end
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/cse_pkg.sv
hw/rtl/cse_mulq.sv
hw/rtl/cubic_spline_evaluator_unit.sv
tb/tb.sv
